### rtl/hdrtm_pkg.sv
// ----------------------------------------------------------------------------
// hdrtm_pkg
// Shared constants, stage counts and elaboration-time curve tables for the
// HDR tone map / sRGB pixel pipeline.
// ----------------------------------------------------------------------------
package hdrtm_pkg;

  localparam int CURVE_TABLE_ENTRIES = 256;
  localparam int CTE_W = $clog2(CURVE_TABLE_ENTRIES + 1);
  localparam int OCTAVES = 17;
  localparam int OCT_W = $clog2(OCTAVES);

  localparam int FRONT_STAGES = 4;
  localparam int DIV_STEPS = 16;
  localparam int ENC_STAGES = 5;
  localparam int NUM_STAGES = FRONT_STAGES + DIV_STEPS + ENC_STAGES;
  localparam int DIV_BASE = FRONT_STAGES;
  localparam int ENC_BASE = FRONT_STAGES + DIV_STEPS;

  localparam int NUM_W = 50;
  localparam int DEN_W = 30;
  localparam int REM_W = 46;

  localparam logic [23:0] KNEE_Q16 = 24'd52429;
  localparam logic [16:0] ONE_Q16 = 17'h10000;
  localparam logic [15:0] LUM_W_R = 16'd13933;
  localparam logic [15:0] LUM_W_G = 16'd46871;
  localparam logic [15:0] LUM_W_B = 16'd4732;
  localparam logic [23:0] LUM_MIN = 24'd6;
  localparam logic [16:0] LIN_MAX = 17'd205;
  localparam logic [18:0] LIN_MUL = 19'd329460;
  localparam logic [26:0] LIN_ADD = 27'd3276800;
  localparam logic [10:0] DIV100_MUL = 11'd1311;
  localparam logic [16:0] DIV10_MUL = 17'd104858;
  localparam logic [18:0] ENC_MUL = 19'd269025;
  localparam logic [35:0] ENC_OFS = 36'd886374400;
  localparam logic [19:0] DIV1000_MUL = 20'd536871;

  typedef logic [63:0] u64_t;
  typedef logic [16:0] tab_val_t;
  typedef tab_val_t curve_tab_t [CURVE_TABLE_ENTRIES + 1];
  typedef tab_val_t oct_tab_t [OCTAVES];
  typedef u64_t root_tab_t [31];

  localparam u64_t ONE30 = 64'd1 << 30;
  localparam u64_t MASK30 = ONE30 - 64'd1;
  localparam u64_t LOG2E_Q30 = 64'd1549082005;
  localparam u64_t CTE_U = u64_t'(CURVE_TABLE_ENTRIES);

  function automatic u64_t isqrt64(u64_t v_in);
    u64_t v;
    u64_t res;
    u64_t bit_v;
    v = v_in;
    res = '0;
    bit_v = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (bit_v > v) bit_v = bit_v >> 2;
    end
    for (int k = 0; k < 32; k++) begin
      if (bit_v != 0) begin
        if (v >= res + bit_v) begin
          v = v - (res + bit_v);
          res = (res >> 1) + bit_v;
        end else begin
          res = res >> 1;
        end
        bit_v = bit_v >> 2;
      end
    end
    return res;
  endfunction

  function automatic root_tab_t build_roots();
    root_tab_t rt;
    rt[0] = 2 * ONE30;
    rt[1] = isqrt64(64'd1 << 61);
    for (int i = 2; i <= 30; i++) rt[i] = isqrt64(rt[i-1] << 30);
    return rt;
  endfunction

  // log2 of x >= 1.0 in Q30
  function automatic u64_t log2_q30(u64_t x_in);
    u64_t x;
    u64_t e;
    u64_t frac;
    x = x_in;
    e = '0;
    frac = '0;
    for (int k = 0; k < 64; k++) begin
      if (x >= 2 * ONE30) begin
        x = x >> 1;
        e = e + 64'd1;
      end
    end
    for (int i = 1; i <= 30; i++) begin
      x = (x * x) >> 30;
      if (x >= 2 * ONE30) begin
        x = x >> 1;
        frac = frac | (64'd1 << (30 - i));
      end
    end
    return e * ONE30 + frac;
  endfunction

  // 2^(+/-mag) with mag in Q30, result Q30
  function automatic u64_t exp2_q30(root_tab_t rt, u64_t mag, logic neg);
    u64_t n;
    u64_t f;
    u64_t r;
    r = ONE30;
    if (!neg) begin
      n = mag >> 30;
      f = mag & MASK30;
    end else begin
      n = (mag + MASK30) >> 30;
      f = n * ONE30 - mag;
    end
    for (int i = 1; i <= 30; i++) begin
      if (f[30-i]) r = (r * rt[i]) >> 30;
    end
    if (!neg) begin
      if (n > 64'd32) n = 64'd32;
      r = r << n;
    end else if (n >= 64'd63) begin
      r = '0;
    end else begin
      r = r >> n;
    end
    return r;
  endfunction

  function automatic tab_val_t q30_to_q16(u64_t v);
    u64_t t;
    t = (v + (64'd1 << 13)) >> 14;
    return t[16:0];
  endfunction

  function automatic curve_tab_t build_exp();
    curve_tab_t tab;
    root_tab_t rt;
    u64_t t26;
    u64_t y;
    rt = build_roots();
    for (int i = 0; i <= CURVE_TABLE_ENTRIES; i++) begin
      t26 = ((64'd16 * u64_t'(i)) << 26) / CTE_U;
      y = (t26 * LOG2E_Q30) >> 26;
      tab[i] = q30_to_q16(exp2_q30(rt, y, 1'b1));
    end
    return tab;
  endfunction

  function automatic curve_tab_t build_pow();
    curve_tab_t tab;
    root_tab_t rt;
    u64_t m;
    u64_t y;
    rt = build_roots();
    for (int i = 0; i <= CURVE_TABLE_ENTRIES; i++) begin
      m = ONE30 + (u64_t'(i) << 30) / CTE_U;
      y = log2_q30(m) * 64'd5 / 64'd12;
      tab[i] = q30_to_q16(exp2_q30(rt, y, 1'b0));
    end
    return tab;
  endfunction

  function automatic oct_tab_t build_oct();
    oct_tab_t tab;
    root_tab_t rt;
    rt = build_roots();
    for (int i = 0; i < OCTAVES; i++) begin
      tab[i] = q30_to_q16(exp2_q30(rt, (u64_t'(i) * 64'd5 * ONE30) / 64'd12, 1'b1));
    end
    return tab;
  endfunction

  localparam curve_tab_t EXP_TAB = build_exp();
  localparam curve_tab_t POW_TAB = build_pow();
  localparam oct_tab_t OCT_TAB = build_oct();

endpackage

### rtl/hdrtm_div.sv
// ----------------------------------------------------------------------------
// hdrtm_div
// Restoring divider, one quotient bit per stage, giving the Reinhard-scaled
// channel saturated to 1.0, or the bypass value.
// ----------------------------------------------------------------------------
module hdrtm_div import hdrtm_pkg::*; (
  input  logic                 clk,
  input  logic [DIV_STEPS-1:0] en,
  input  logic [NUM_W-1:0]     numer,
  input  logic [DEN_W-1:0]     den,
  input  logic                 scale,
  input  logic [16:0]          alt,
  output logic [16:0]          c_out
);

  logic [REM_W-1:0] rem_r   [DIV_STEPS];
  logic [15:0]      quo_r   [DIV_STEPS];
  logic [DEN_W-1:0] den_r   [DIV_STEPS];
  logic             sat_r   [DIV_STEPS];
  logic             scale_r [DIV_STEPS];
  logic [16:0]      alt_r   [DIV_STEPS];

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
    logic [REM_W-1:0] rem_in;
    logic [15:0]      quo_in;
    logic [DEN_W-1:0] den_in;
    logic             sat_in;
    logic             scale_in;
    logic [16:0]      alt_in;
    logic [REM_W-1:0] dsh;
    logic [REM_W-1:0] rem_nxt;
    logic [15:0]      quo_nxt;

    if (j == 0) begin : g_first
      assign rem_in   = numer[REM_W-1:0];
      assign quo_in   = '0;
      assign den_in   = den;
      assign sat_in   = numer[NUM_W-1:16] >= (NUM_W-16)'(den);
      assign scale_in = scale;
      assign alt_in   = alt;
    end else begin : g_next
      assign rem_in   = rem_r[j-1];
      assign quo_in   = quo_r[j-1];
      assign den_in   = den_r[j-1];
      assign sat_in   = sat_r[j-1];
      assign scale_in = scale_r[j-1];
      assign alt_in   = alt_r[j-1];
    end

    always_comb begin
      dsh = REM_W'(den_in) << (DIV_STEPS - 1 - j);
      rem_nxt = rem_in;
      quo_nxt = quo_in;
      if (rem_in >= dsh) begin
        rem_nxt = rem_in - dsh;
        quo_nxt[DIV_STEPS-1-j] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (en[j]) begin
        rem_r[j]   <= rem_nxt;
        quo_r[j]   <= quo_nxt;
        den_r[j]   <= den_in;
        sat_r[j]   <= sat_in;
        scale_r[j] <= scale_in;
        alt_r[j]   <= alt_in;
      end
    end
  end

  always_comb begin
    if (!scale_r[DIV_STEPS-1]) c_out = alt_r[DIV_STEPS-1];
    else if (sat_r[DIV_STEPS-1]) c_out = ONE_Q16;
    else c_out = {1'b0, quo_r[DIV_STEPS-1]};
  end

endmodule

### rtl/hdrtm_enc.sv
// ----------------------------------------------------------------------------
// hdrtm_enc
// sRGB transfer curve on a Q16 value clamped to 1.0: linear segment near
// zero, otherwise table power curve per octave, rounded to an 8-bit code.
// ----------------------------------------------------------------------------
module hdrtm_enc import hdrtm_pkg::*; (
  input  logic                  clk,
  input  logic [ENC_STAGES-1:0] en,
  input  logic [16:0]           c_in,
  output logic [7:0]            code
);

  localparam int POS_W = 16 + CTE_W;

  // stage 0
  logic              big0_r, lin0_r;
  logic [10:0]       lind0_r;
  logic [OCT_W-1:0]  oct0_r;
  logic [CTE_W-1:0]  idx0_r;
  logic [15:0]       fr0_r;
  logic [OCT_W-1:0]  lz_nxt;
  logic [16:0]       mant_nxt;
  logic [POS_W-1:0]  pos_nxt;
  logic [26:0]       lin_nxt;

  always_comb begin
    lz_nxt = '0;
    for (int b = 0; b < 16; b++) begin
      if (c_in[b]) lz_nxt = OCT_W'(16 - b);
    end
    mant_nxt = 17'(c_in[15:0]) << lz_nxt;
    pos_nxt  = POS_W'(mant_nxt[15:0]) * POS_W'(CURVE_TABLE_ENTRIES);
    lin_nxt  = 27'(c_in[7:0]) * 27'(LIN_MUL) + LIN_ADD;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      big0_r  <= c_in[16];
      lin0_r  <= c_in <= LIN_MAX;
      lind0_r <= lin_nxt[26:16];
      oct0_r  <= lz_nxt;
      idx0_r  <= pos_nxt[POS_W-1:16];
      fr0_r   <= pos_nxt[15:0];
    end
  end

  // stage 1
  logic             big1_r, lin1_r;
  logic [7:0]       linc1_r;
  logic [OCT_W-1:0] oct1_r;
  logic [16:0]      pv1_r;
  logic [16:0]      p0, p1;
  logic [33:0]      pint;
  logic [21:0]      lq;

  always_comb begin
    p0   = POW_TAB[idx0_r];
    p1   = POW_TAB[CTE_W'(idx0_r + 1'b1)];
    pint = 34'(p1 - p0) * 34'(fr0_r) + 34'd32768;
    lq   = 22'(lind0_r) * 22'(DIV100_MUL);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      big1_r  <= big0_r;
      lin1_r  <= lin0_r;
      linc1_r <= 8'(lq[21:17]);
      oct1_r  <= oct0_r;
      pv1_r   <= p0 + pint[32:16];
    end
  end

  // stage 2
  logic        big2_r, lin2_r;
  logic [7:0]  linc2_r;
  logic [16:0] pw2_r;
  logic [33:0] pw_nxt;

  assign pw_nxt = 34'(pv1_r) * 34'(OCT_TAB[oct1_r]) + 34'd32768;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      big2_r  <= big1_r;
      lin2_r  <= lin1_r;
      linc2_r <= linc1_r;
      pw2_r   <= pw_nxt[32:16];
    end
  end

  // stage 3
  logic        big3_r, lin3_r;
  logic [7:0]  linc3_r;
  logic [19:0] b3_r;
  logic [35:0] num_nxt;

  assign num_nxt = 36'(pw2_r) * 36'(ENC_MUL);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      big3_r  <= big2_r;
      lin3_r  <= lin2_r;
      linc3_r <= linc2_r;
      if (num_nxt < ENC_OFS) b3_r <= '0;
      else b3_r <= 20'((num_nxt - ENC_OFS) >> 16);
    end
  end

  // stage 4
  logic [39:0] q_nxt;
  logic [7:0]  code_r;

  assign q_nxt = 40'(b3_r) * 40'(DIV1000_MUL);

  always_ff @(posedge clk) begin
    if (en[4]) begin
      if (big3_r) code_r <= 8'hFF;
      else if (lin3_r) code_r <= linc3_r;
      else if (q_nxt[39:29] > 11'd255) code_r <= 8'hFF;
      else code_r <= q_nxt[36:29];
    end
  end

  assign code = code_r;

endmodule

### rtl/hdr_tone_map_srgb_pixel_top.sv
// ----------------------------------------------------------------------------
// hdr_tone_map_srgb_pixel_top
// Half-float linear RGB to 8-bit sRGB: Reinhard on luminance (HDR mode) or
// per-channel exponential knee (SDR mode), then the sRGB curve.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_ready  in_red_half, in_green_half, in_blue_half
//   out      output     out_valid/out_ready  out_red_code, out_green_code, out_blue_code
//   cfg      input      cfg_wr_en            cfg_wr_data (hdr_mode)
//
// One request per cycle unless out_ready back-pressure stalls the pipeline;
// there are 4 front stages, 16 divider steps and 5 encoder stages. Each stage
// holds its request until the next stage frees up, so bubbles collapse and a
// stall drops nothing. Synchronous active-low reset clears the valid bits and hdr_mode.
// ----------------------------------------------------------------------------
module hdr_tone_map_srgb_pixel_top import hdrtm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_red_half,
  input  logic [15:0] in_green_half,
  input  logic [15:0] in_blue_half,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_red_code,
  output logic [7:0]  out_green_code,
  output logic [7:0]  out_blue_code
);

  localparam int PROD_W = 20 + CTE_W;

  function automatic logic [23:0] half_to_q16(logic [15:0] h);
    logic [4:0]  e;
    logic [34:0] wide;
    logic [23:0] res;
    e = h[14:10];
    wide = '0;
    if (h[15]) res = '0;
    else if (e == 5'd31) res = (h[9:0] != 10'd0) ? 24'd0 : 24'hFFFFFF;
    else if (e == 5'd0) res = 24'((11'(h[9:0]) + 11'd128) >> 8);
    else if (e >= 5'd23) res = 24'hFFFFFF;
    else if (e >= 5'd9) begin
      wide = 35'({1'b1, h[9:0]}) << (e - 5'd9);
      res = wide[23:0];
    end else begin
      wide = (35'({1'b1, h[9:0]}) + (35'd1 << (5'd8 - e))) >> (5'd9 - e);
      res = wide[23:0];
    end
    return res;
  endfunction

  function automatic logic [16:0] sat17(logic [23:0] v);
    return (v[23:16] != 8'd0) ? ONE_Q16 : {1'b0, v[15:0]};
  endfunction

  // handshake / stage control
  logic [NUM_STAGES-1:0] v_r;
  logic [NUM_STAGES-1:0] adv;
  logic                  mode_r;

  always_comb begin
    adv[NUM_STAGES-1] = !v_r[NUM_STAGES-1] || out_ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) adv[k] = !v_r[k] || adv[k+1];
  end

  assign in_ready  = adv[0];
  assign out_valid = v_r[NUM_STAGES-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r    <= '0;
      mode_r <= 1'b0;
    end else begin
      if (cfg_wr_en) mode_r <= cfg_wr_data;
      if (adv[0]) v_r[0] <= in_valid;
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (adv[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // stage 0: decode
  logic [23:0] ch0_r [3];

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      ch0_r[0] <= half_to_q16(in_red_half);
      ch0_r[1] <= half_to_q16(in_green_half);
      ch0_r[2] <= half_to_q16(in_blue_half);
    end
  end

  // stage 1: luminance products, knee table position
  logic [15:0] lum_w [3];
  logic [23:0] ch1_r [3];
  logic [39:0] lp1_r [3];
  logic        kov1_r [3];
  logic        klast1_r [3];
  logic [CTE_W-1:0] kidx1_r [3];
  logic [15:0] kfr1_r [3];

  assign lum_w[0] = LUM_W_R;
  assign lum_w[1] = LUM_W_G;
  assign lum_w[2] = LUM_W_B;

  for (genvar c = 0; c < 3; c++) begin : g_s1
    logic [26:0]       xk;
    logic [PROD_W-1:0] prod;
    assign xk   = 27'(ch0_r[c] - KNEE_Q16) * 27'd5;
    assign prod = PROD_W'(xk[19:0]) * PROD_W'(CURVE_TABLE_ENTRIES);
    always_ff @(posedge clk) begin
      if (adv[1]) begin
        ch1_r[c]    <= ch0_r[c];
        lp1_r[c]    <= 40'(lum_w[c]) * 40'(ch0_r[c]);
        kov1_r[c]   <= ch0_r[c] > KNEE_Q16;
        klast1_r[c] <= xk[26:20] != 7'd0;
        kidx1_r[c]  <= prod[PROD_W-1:20];
        kfr1_r[c]   <= prod[19:4];
      end
    end
  end

  // stage 2: luminance, Reinhard factors, knee interpolation
  logic [40:0]      lsum;
  logic [23:0]      lum;
  logic [23:0]      ch2_r [3];
  logic             kov2_r [3];
  logic [16:0]      ev2_r [3];
  logic [24:0]      nf2_r;
  logic [DEN_W-1:0] den2_r;
  logic             scale2_r;

  assign lsum = 41'(lp1_r[0]) + 41'(lp1_r[1]) + 41'(lp1_r[2]) + 41'd32768;
  assign lum  = lsum[39:16];

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      nf2_r    <= 25'd2359296 + 25'(lum);
      den2_r   <= (DEN_W'(65536) + DEN_W'(lum)) * DEN_W'(36);
      scale2_r <= mode_r && (lum > LUM_MIN);
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_s2
    logic [16:0] e0, e1, ev;
    logic [33:0] t;
    always_comb begin
      e0 = EXP_TAB[kidx1_r[c]];
      e1 = EXP_TAB[CTE_W'(kidx1_r[c] + 1'b1)];
      t  = 34'(e0 - e1) * 34'(kfr1_r[c]) + 34'd32768;
      ev = e0 - t[32:16];
      if (klast1_r[c]) ev = EXP_TAB[CURVE_TABLE_ENTRIES];
      if (ev > ONE_Q16) ev = ONE_Q16;
    end
    always_ff @(posedge clk) begin
      if (adv[2]) begin
        ch2_r[c]  <= ch1_r[c];
        kov2_r[c] <= kov1_r[c];
        ev2_r[c]  <= ev;
      end
    end
  end

  // stage 3: dividend, knee result
  logic [NUM_W-1:0] num3_r [3];
  logic [16:0]      alt3_r [3];
  logic [DEN_W-1:0] den3_r;
  logic             scale3_r;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      den3_r   <= den2_r;
      scale3_r <= scale2_r;
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_s3
    logic [17:0] u;
    logic [34:0] kq;
    logic [16:0] knee;
    always_comb begin
      u    = (18'(ONE_Q16) - 18'(ev2_r[c])) * 18'd2 + 18'd5;
      kq   = 35'(u) * 35'(DIV10_MUL);
      knee = 17'(KNEE_Q16) + 17'(kq[34:20]);
    end
    always_ff @(posedge clk) begin
      if (adv[3]) begin
        num3_r[c] <= NUM_W'(ch2_r[c]) * NUM_W'(nf2_r) + NUM_W'(den2_r >> 1);
        alt3_r[c] <= (mode_r || !kov2_r[c]) ? sat17(ch2_r[c]) : knee;
      end
    end
  end

  // divider and encoder
  logic [16:0] cdiv [3];
  logic [7:0]  code [3];

  for (genvar c = 0; c < 3; c++) begin : g_ch
    hdrtm_div u_div (
      .clk   (clk),
      .en    (adv[DIV_BASE +: DIV_STEPS]),
      .numer (num3_r[c]),
      .den   (den3_r),
      .scale (scale3_r),
      .alt   (alt3_r[c]),
      .c_out (cdiv[c])
    );
    hdrtm_enc u_enc (
      .clk  (clk),
      .en   (adv[ENC_BASE +: ENC_STAGES]),
      .c_in (cdiv[c]),
      .code (code[c])
    );
  end

  assign out_red_code   = code[0];
  assign out_green_code = code[1];
  assign out_blue_code  = code[2];

  // checks
  assert property (@(posedge clk) disable iff (!rst_n)
    (&v_r && !out_ready) |-> !in_ready)
    else $error("full pipeline accepted a request");

  assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (v_r[NUM_STAGES-1] && !out_ready))
    else $error("input stalled without output back-pressure");

  assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> ($countones(v_r) == $past($countones(v_r))
              + int'($past(in_valid && in_ready))
              - int'($past(out_valid && out_ready))))
    else $error("request count in pipeline mismatch");

endmodule
